@@ src/trapezoidal_motion_profile_macros.svh @@
// ----------------------------------------------------------------------------
// Trapezoidal motion profile assertion macros
// Shared property templates for the checkers of the motion profile block.
// ----------------------------------------------------------------------------
`ifndef TRAPEZOIDAL_MOTION_PROFILE_MACROS_SVH
`define TRAPEZOIDAL_MOTION_PROFILE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TMPROF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TMPROF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/tmprof_pkg.sv @@
// ----------------------------------------------------------------------------
// Trapezoidal motion profile package
// Register indexes, timing constants and the derived-profile record.
// ----------------------------------------------------------------------------
`default_nettype none

package tmprof_pkg;

    // Register indexes of the configuration port.
    localparam logic [1:0] CFG_DISTANCE  = 2'd0;
    localparam logic [1:0] CFG_VEL_LIMIT = 2'd1;
    localparam logic [1:0] CFG_ACC_LIMIT = 2'd2;

    // Derived times saturate here, beyond any sample time.
    localparam logic [32:0] TIME_CAP = 33'h1_0000_0000;

    // Iteration counts of the shared arithmetic units.
    localparam logic [6:0] MUL_STEPS  = 7'd33;
    localparam logic [6:0] DIV_STEPS  = 7'd64;
    localparam logic [6:0] SQRT_STEPS = 7'd32;

    // Phase of the move that a sample falls into.
    typedef enum logic [2:0] {
        RG_ZERO   = 3'd0,
        RG_DONE   = 3'd1,
        RG_ACCEL  = 3'd2,
        RG_CRUISE = 3'd3,
        RG_DECEL  = 3'd4
    } region_t;

    // Values derived from the registers once per register write.
    typedef struct packed {
        logic        dir_neg;
        logic [31:0] dist_mag;
        logic [30:0] lim_a;
        logic [31:0] peak;
        logic [32:0] t_acc;
        logic [33:0] t_ac;
        logic [34:0] t_tot;
        logic [63:0] dist_acc;
        logic [48:0] dist_cru;
    } profile_t;

    // Saturate a quotient to the time cap.
    function automatic logic [32:0] cap_time(input logic [63:0] q);
        logic [32:0] r;
        if (q > {31'b0, TIME_CAP})
        begin
            r = TIME_CAP;
        end
        else
        begin
            r = q[32:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ src/tmprof_derive.sv @@
// ----------------------------------------------------------------------------
// Trapezoidal motion profile derivation
// Holds the move registers and derives the phase timings with a shared
// serial multiplier, a restoring divider and a bit-pair square root.
// ----------------------------------------------------------------------------
`default_nettype none

module tmprof_derive (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    output tmprof_pkg::profile_t    prof,
    output logic                    busy
);
    import tmprof_pkg::*;

    typedef enum logic [11:0] {
        ST_IDLE = 12'b0000_0000_0001,
        ST_LOAD = 12'b0000_0000_0010,
        ST_VV   = 12'b0000_0000_0100,
        ST_DA   = 12'b0000_0000_1000,
        ST_DQ   = 12'b0000_0001_0000,
        ST_SQ   = 12'b0000_0010_0000,
        ST_DVA  = 12'b0000_0100_0000,
        ST_DTA  = 12'b0000_1000_0000,
        ST_DTC  = 12'b0001_0000_0000,
        ST_AT   = 12'b0010_0000_0000,
        ST_DACC = 12'b0100_0000_0000,
        ST_CRU  = 12'b1000_0000_0000
    } state_t;

    state_t      state_reg, state_next;
    logic [6:0]  cnt_reg;

    logic [31:0] dist_reg;
    logic [30:0] vlim_reg;
    logic [30:0] alim_reg;

    logic [63:0] mul_a_reg;
    logic [63:0] mul_hi_reg;
    logic [32:0] mul_lo_reg;
    logic [63:0] div_num_reg;
    logic [31:0] div_rem_reg;
    logic [63:0] div_q_reg;
    logic [30:0] div_den_reg;
    logic [63:0] sq_x_reg;
    logic [63:0] sq_res_reg;
    logic [63:0] sq_bit_reg;

    logic [61:0] vv_reg;
    logic        tri_reg;
    logic [31:0] rem_reg;
    logic [31:0] peak_reg;
    logic [32:0] ta_reg;
    logic [32:0] tc_reg;
    logic [63:0] dacc_reg;
    logic [48:0] dcru_reg;
    logic [34:0] tot_reg;
    logic [33:0] tac_reg;

    logic        dir_neg;
    logic [31:0] dist_mag;
    logic [30:0] lim_v;
    logic [30:0] lim_a;
    logic        cfg_we;
    logic        start;
    logic        step_done;

    logic        mul_load, div_load, sq_load;
    logic [63:0] mul_ld_a;
    logic [32:0] mul_ld_b;
    logic [63:0] div_ld_num;
    logic [30:0] div_ld_den;
    logic [63:0] sq_ld_x;
    logic        mul_run, div_run, sq_run;

    logic [64:0] mul_sum;
    logic [96:0] mul_prod;
    logic [32:0] div_trial;
    logic        div_ge;
    logic [32:0] div_diff;
    logic [64:0] sq_trial;
    logic        sq_ge;

    // Register views: direction, magnitude, and limits with zero read as one.
    assign dir_neg  = dist_reg[31];
    assign dist_mag = dir_neg ? (~dist_reg + 32'd1) : dist_reg;
    assign lim_v    = (vlim_reg == 31'd0) ? 31'd1 : vlim_reg;
    assign lim_a    = (alim_reg == 31'd0) ? 31'd1 : alim_reg;

    assign cfg_ready = (state_reg == ST_IDLE);
    assign busy      = !cfg_ready;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign start     = cfg_we && (cfg_index == CFG_DISTANCE || cfg_index == CFG_VEL_LIMIT
                                  || cfg_index == CFG_ACC_LIMIT);
    assign step_done = (cnt_reg == 7'd0);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_reg <= 32'd0;
            vlim_reg <= 31'd65536;
            alim_reg <= 31'd65536;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DISTANCE:  dist_reg <= cfg_data;
                CFG_VEL_LIMIT: vlim_reg <= cfg_data[30:0];
                CFG_ACC_LIMIT: alim_reg <= cfg_data[30:0];
                default:       ;
            endcase
        end
    end

    // Sequencer: chooses the next operation and loads its operands.
    always_comb
    begin
        state_next = state_reg;
        mul_load   = 1'b0;
        mul_ld_a   = '0;
        mul_ld_b   = '0;
        div_load   = 1'b0;
        div_ld_num = '0;
        div_ld_den = '0;
        sq_load    = 1'b0;
        sq_ld_x    = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                mul_load   = 1'b1;
                mul_ld_a   = {33'b0, lim_v};
                mul_ld_b   = {2'b0, lim_v};
                state_next = ST_VV;
            end
            ST_VV:
            begin
                if (step_done)
                begin
                    mul_load   = 1'b1;
                    mul_ld_a   = {32'b0, dist_mag};
                    mul_ld_b   = {2'b0, lim_a};
                    state_next = ST_DA;
                end
            end
            ST_DA:
            begin
                if (step_done)
                begin
                    div_load   = 1'b1;
                    div_ld_den = lim_a;
                    if (vv_reg >= mul_prod[61:0])
                    begin
                        div_ld_num = {dist_mag, 32'b0};
                        state_next = ST_DQ;
                    end
                    else
                    begin
                        div_ld_num = {2'b0, vv_reg};
                        state_next = ST_DVA;
                    end
                end
            end
            ST_DQ:
            begin
                if (step_done)
                begin
                    sq_load    = 1'b1;
                    sq_ld_x    = div_q_reg;
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                if (step_done)
                begin
                    mul_load   = 1'b1;
                    mul_ld_a   = {33'b0, lim_a};
                    mul_ld_b   = cap_time(sq_res_reg);
                    state_next = ST_AT;
                end
            end
            ST_DVA:
            begin
                if (step_done)
                begin
                    div_load   = 1'b1;
                    div_ld_num = {17'b0, lim_v, 16'b0};
                    div_ld_den = lim_a;
                    state_next = ST_DTA;
                end
            end
            ST_DTA:
            begin
                if (step_done)
                begin
                    div_load   = 1'b1;
                    div_ld_num = {16'b0, rem_reg, 16'b0};
                    div_ld_den = lim_v;
                    state_next = ST_DTC;
                end
            end
            ST_DTC:
            begin
                if (step_done)
                begin
                    mul_load   = 1'b1;
                    mul_ld_a   = {33'b0, lim_a};
                    mul_ld_b   = ta_reg;
                    state_next = ST_AT;
                end
            end
            ST_AT:
            begin
                if (step_done)
                begin
                    mul_load   = 1'b1;
                    mul_ld_a   = mul_prod[63:0];
                    mul_ld_b   = ta_reg;
                    state_next = ST_DACC;
                end
            end
            ST_DACC:
            begin
                if (step_done)
                begin
                    mul_load   = 1'b1;
                    mul_ld_a   = {32'b0, peak_reg};
                    mul_ld_b   = tc_reg;
                    state_next = ST_CRU;
                end
            end
            ST_CRU:
            begin
                if (step_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Which unit is iterating this cycle.
    assign mul_run = !step_done && (state_reg == ST_VV || state_reg == ST_DA
                     || state_reg == ST_AT || state_reg == ST_DACC || state_reg == ST_CRU);
    assign div_run = !step_done && (state_reg == ST_DQ || state_reg == ST_DVA
                     || state_reg == ST_DTA || state_reg == ST_DTC);
    assign sq_run  = !step_done && (state_reg == ST_SQ);

    // Step counter of the active unit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 7'd0;
        end
        else if (mul_load)
        begin
            cnt_reg <= MUL_STEPS;
        end
        else if (div_load)
        begin
            cnt_reg <= DIV_STEPS;
        end
        else if (sq_load)
        begin
            cnt_reg <= SQRT_STEPS;
        end
        else if (mul_run || div_run || sq_run)
        begin
            cnt_reg <= cnt_reg - 7'd1;
        end
    end

    // Shift-add multiplier: one multiplier bit per cycle, product in {hi, lo}.
    assign mul_sum  = {1'b0, mul_hi_reg} + (mul_lo_reg[0] ? {1'b0, mul_a_reg} : 65'd0);
    assign mul_prod = {mul_hi_reg, mul_lo_reg};

    always_ff @(posedge clk)
    begin
        if (mul_load)
        begin
            mul_a_reg  <= mul_ld_a;
            mul_hi_reg <= 64'd0;
            mul_lo_reg <= mul_ld_b;
        end
        else if (mul_run)
        begin
            mul_hi_reg <= mul_sum[64:1];
            mul_lo_reg <= {mul_sum[0], mul_lo_reg[32:1]};
        end
    end

    // Restoring divider: one quotient bit per cycle.
    assign div_trial = {div_rem_reg, div_num_reg[63]};
    assign div_ge    = (div_trial >= {2'b0, div_den_reg});
    assign div_diff  = div_trial - {2'b0, div_den_reg};

    always_ff @(posedge clk)
    begin
        if (div_load)
        begin
            div_num_reg <= div_ld_num;
            div_den_reg <= div_ld_den;
            div_rem_reg <= 32'd0;
            div_q_reg   <= 64'd0;
        end
        else if (div_run)
        begin
            div_num_reg <= {div_num_reg[62:0], 1'b0};
            div_rem_reg <= div_ge ? div_diff[31:0] : div_trial[31:0];
            div_q_reg   <= {div_q_reg[62:0], div_ge};
        end
    end

    // Square root: one result bit per cycle, two radicand bits at a time.
    assign sq_trial = {1'b0, sq_res_reg} + {1'b0, sq_bit_reg};
    assign sq_ge    = ({1'b0, sq_x_reg} >= sq_trial);

    always_ff @(posedge clk)
    begin
        if (sq_load)
        begin
            sq_x_reg   <= sq_ld_x;
            sq_res_reg <= 64'd0;
            sq_bit_reg <= 64'h4000_0000_0000_0000;
        end
        else if (sq_run)
        begin
            if (sq_ge)
            begin
                sq_x_reg   <= sq_x_reg - sq_trial[63:0];
                sq_res_reg <= {1'b0, sq_res_reg[63:1]} + sq_bit_reg;
            end
            else
            begin
                sq_res_reg <= {1'b0, sq_res_reg[63:1]};
            end
            sq_bit_reg <= {2'b0, sq_bit_reg[63:2]};
        end
    end

    // Capture the results of each finished operation.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vv_reg   <= 62'd0;
            tri_reg  <= 1'b1;
            rem_reg  <= 32'd0;
            peak_reg <= 32'd0;
            ta_reg   <= 33'd0;
            tc_reg   <= 33'd0;
            dacc_reg <= 64'd0;
            dcru_reg <= 49'd0;
            tot_reg  <= 35'd0;
            tac_reg  <= 34'd0;
        end
        else if (step_done)
        begin
            unique case (state_reg)
                ST_VV:   vv_reg <= mul_prod[61:0];
                ST_DA:   tri_reg <= (vv_reg >= mul_prod[61:0]);
                ST_SQ:
                begin
                    ta_reg <= cap_time(sq_res_reg);
                    tc_reg <= 33'd0;
                end
                ST_DVA:  rem_reg <= dist_mag - div_q_reg[31:0];
                ST_DTA:  ta_reg <= cap_time(div_q_reg);
                ST_DTC:
                begin
                    tc_reg   <= cap_time(div_q_reg);
                    peak_reg <= {1'b0, lim_v};
                end
                ST_AT:
                begin
                    if (tri_reg)
                    begin
                        peak_reg <= mul_prod[47:16];
                    end
                end
                ST_DACC: dacc_reg <= mul_prod[96:33];
                ST_CRU:
                begin
                    dcru_reg <= mul_prod[64:16];
                    tot_reg  <= {1'b0, ta_reg, 1'b0} + {2'b0, tc_reg};
                    tac_reg  <= {1'b0, ta_reg} + {1'b0, tc_reg};
                end
                default: ;
            endcase
        end
    end

    // Derived profile as seen by the sample pipeline.
    always_comb
    begin
        prof.dir_neg  = dir_neg;
        prof.dist_mag = dist_mag;
        prof.lim_a    = lim_a;
        prof.peak     = peak_reg;
        prof.t_acc    = ta_reg;
        prof.t_ac     = tac_reg;
        prof.t_tot    = tot_reg;
        prof.dist_acc = dacc_reg;
        prof.dist_cru = dcru_reg;
    end

endmodule

`default_nettype wire

@@ src/trapezoidal_motion_profile.sv @@
// An accepted sample passes the stage 1 to 4 registers and then the result register.
// Throughput: one sample per cycle through this five-register pipeline, unless
// result_stall holds it or a register write or derivation stalls samples. A register
// write starts a derivation in the serial units that holds off samples.
// Reset: distance 0, both limits 1.0; every sample then reads all zeros.
// ----------------------------------------------------------------------------
// Trapezoidal motion profile
// Returns position, velocity and acceleration of a point-to-point move.
// ----------------------------------------------------------------------------
`default_nettype none

module trapezoidal_motion_profile (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    input  wire logic               sample_valid,
    output logic                    sample_stall,
    input  wire logic [31:0]        sample_time,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic signed [31:0]      position,
    output logic signed [31:0]      velocity,
    output logic signed [31:0]      acceleration
);
    import tmprof_pkg::*;

    profile_t    prof;
    logic        busy;

    logic        rdy1, rdy2, rdy3, rdy4, rdy5;
    logic        accept;
    region_t     rg_in;
    logic [31:0] x_in;

    logic        s1_valid_reg;
    region_t     s1_rg_reg;
    logic [31:0] s1_x_reg;

    logic        s2_valid_reg;
    region_t     s2_rg_reg;
    logic [31:0] s2_x_reg;
    logic [62:0] s2_m1_reg;
    logic [63:0] s2_m2_reg;

    logic        s3_valid_reg;
    region_t     s3_rg_reg;
    logic [63:0] s3_plo_reg;
    logic [62:0] s3_phi_reg;
    logic [46:0] s3_vx_reg;
    logic [47:0] s3_pe_reg;

    logic        s4_valid_reg;
    region_t     s4_rg_reg;
    logic [61:0] s4_sq_reg;
    logic [31:0] s4_vel_reg;
    logic [63:0] s4_base_reg;

    logic [94:0] sq_full;
    logic [31:0] vel_next;
    logic [63:0] base_next;

    logic [64:0] pos_raw;
    logic [31:0] pos_mag;
    logic [31:0] vel_mag;
    logic [31:0] acc_val;
    logic [31:0] lim_a_ext;

    logic        result_valid_reg;
    logic [31:0] position_reg;
    logic [31:0] velocity_reg;
    logic [31:0] acceleration_reg;

    tmprof_derive u_derive (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .prof      (prof),
        .busy      (busy)
    );

    // Backpressure chain: a stage moves when it is empty or its successor moves.
    assign rdy5 = !result_valid_reg || !result_stall;
    assign rdy4 = !s4_valid_reg || rdy5;
    assign rdy3 = !s3_valid_reg || rdy4;
    assign rdy2 = !s2_valid_reg || rdy3;
    assign rdy1 = !s1_valid_reg || rdy2;

    assign sample_stall = busy || cfg_valid || !rdy1;
    assign accept       = sample_valid && !sample_stall;

    // Stage 1: classify the sample time and form the time within its phase.
    always_comb
    begin
        x_in = sample_time;
        if (sample_time == 32'd0 || prof.dist_mag == 32'd0)
        begin
            rg_in = RG_ZERO;
        end
        else if ({3'b0, sample_time} >= prof.t_tot)
        begin
            rg_in = RG_DONE;
        end
        else if ({1'b0, sample_time} < prof.t_acc)
        begin
            rg_in = RG_ACCEL;
        end
        else if ({2'b0, sample_time} < prof.t_ac)
        begin
            rg_in = RG_CRUISE;
            x_in  = sample_time - prof.t_acc[31:0];
        end
        else
        begin
            rg_in = RG_DECEL;
            x_in  = sample_time - prof.t_ac[31:0];
        end
    end

    // Valid bits of all stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            s4_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                s1_valid_reg <= accept;
            end
            if (rdy2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (rdy3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (rdy4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (rdy5)
            begin
                result_valid_reg <= s4_valid_reg;
            end
        end
    end

    // Stage 1 and 2 payload: phase time, then acceleration and peak products.
    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            s1_rg_reg <= rg_in;
            s1_x_reg  <= x_in;
        end
        if (rdy2)
        begin
            s2_rg_reg <= s1_rg_reg;
            s2_x_reg  <= s1_x_reg;
            s2_m1_reg <= 63'(prof.lim_a) * 63'(s1_x_reg);
            s2_m2_reg <= 64'(prof.peak) * 64'(s1_x_reg);
        end
    end

    // Stage 3: the square term in two partial products.
    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            s3_rg_reg  <= s2_rg_reg;
            s3_plo_reg <= 64'(s2_m1_reg[31:0]) * 64'(s2_x_reg);
            s3_phi_reg <= 63'(s2_m1_reg[62:32]) * 63'(s2_x_reg);
            s3_vx_reg  <= s2_m1_reg[62:16];
            s3_pe_reg  <= s2_m2_reg[63:16];
        end
    end

    // Stage 4: combine the partial products, velocity and position base.
    assign sq_full = {s3_phi_reg, 32'b0} + 95'(s3_plo_reg);

    always_comb
    begin
        vel_next  = 32'd0;
        base_next = 64'd0;
        case (s3_rg_reg)
            RG_ACCEL:
            begin
                vel_next = s3_vx_reg[31:0];
            end
            RG_CRUISE:
            begin
                vel_next  = prof.peak;
                base_next = prof.dist_acc + 64'(s3_pe_reg);
            end
            RG_DECEL:
            begin
                if (s3_vx_reg <= {15'b0, prof.peak})
                begin
                    vel_next = prof.peak - s3_vx_reg[31:0];
                end
                base_next = prof.dist_acc + 64'(prof.dist_cru) + 64'(s3_pe_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            s4_rg_reg   <= s3_rg_reg;
            s4_sq_reg   <= sq_full[94:33];
            s4_vel_reg  <= vel_next;
            s4_base_reg <= base_next;
        end
    end

    // Stage 5: final position with clamping, direction and acceleration sign.
    assign lim_a_ext = {1'b0, prof.lim_a};

    always_comb
    begin
        pos_raw = 65'd0;
        pos_mag = 32'd0;
        vel_mag = 32'd0;
        acc_val = 32'd0;
        case (s4_rg_reg)
            RG_ACCEL:  pos_raw = {3'b0, s4_sq_reg};
            RG_CRUISE: pos_raw = {1'b0, s4_base_reg};
            RG_DECEL:  pos_raw = {1'b0, s4_base_reg} - {3'b0, s4_sq_reg};
            default:   ;
        endcase
        case (s4_rg_reg)
            RG_ZERO: ;
            RG_DONE:
            begin
                pos_mag = prof.dist_mag;
            end
            default:
            begin
                vel_mag = s4_vel_reg;
                if (pos_raw[64])
                begin
                    pos_mag = 32'd0;
                end
                else if (pos_raw > {33'b0, prof.dist_mag})
                begin
                    pos_mag = prof.dist_mag;
                end
                else
                begin
                    pos_mag = pos_raw[31:0];
                end
            end
        endcase
        case (s4_rg_reg)
            RG_ACCEL: acc_val = prof.dir_neg ? (32'd0 - lim_a_ext) : lim_a_ext;
            RG_DECEL: acc_val = prof.dir_neg ? lim_a_ext : (32'd0 - lim_a_ext);
            default:  ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rdy5)
        begin
            position_reg     <= prof.dir_neg ? (32'd0 - pos_mag) : pos_mag;
            velocity_reg     <= prof.dir_neg ? (32'd0 - vel_mag) : vel_mag;
            acceleration_reg <= acc_val;
        end
    end

    assign result_valid = result_valid_reg;
    assign position     = position_reg;
    assign velocity     = velocity_reg;
    assign acceleration = acceleration_reg;

endmodule

`default_nettype wire

@@ src/tmprof_checker.sv @@
// ----------------------------------------------------------------------------
// Trapezoidal motion profile checker
// Port-level properties of the motion profile block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "trapezoidal_motion_profile_macros.svh"

module tmprof_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready,
    input wire logic [1:0]  cfg_index,
    input wire logic        sample_stall,
    input wire logic        result_valid,
    input wire logic        result_stall,
    input wire logic [31:0] position,
    input wire logic [31:0] velocity,
    input wire logic [31:0] acceleration
);
    import tmprof_pkg::*;

    logic        res_wait;
    logic [95:0] res_data;
    logic        wr_start;

    // Result payload and the write that starts a derivation.
    assign res_wait = result_valid && result_stall;
    assign res_data = {position, velocity, acceleration};
    assign wr_start = cfg_valid && cfg_ready
                      && (cfg_index == CFG_DISTANCE || cfg_index == CFG_VEL_LIMIT
                          || cfg_index == CFG_ACC_LIMIT);

    // A stalled result holds its value.
    `TMPROF_ASSERT_NEXT(a_hold, res_wait, result_valid && $stable(res_data), "result changed")

    // A register write starts a derivation that blocks samples and writes.
    `TMPROF_ASSERT_NEXT(a_write_derives, wr_start, sample_stall && !cfg_ready, "no derivation")

    // While the timings are being derived no sample request is taken.
    `TMPROF_ASSERT_SAME(a_busy_stalls, !cfg_ready, sample_stall, "sample during derivation")

endmodule

bind trapezoidal_motion_profile tmprof_checker u_tmprof_checker (.*);

`default_nettype wire
